[rtl/core/prescaled_reload_down_timer_assert.svh]
// Assertion macros for the prescaled reload down timer.
// Included by RTL files that check their own logic; needs clk_i and rst_ni in scope.
`ifndef PRESCALED_RELOAD_DOWN_TIMER_ASSERT_SVH
`define PRESCALED_RELOAD_DOWN_TIMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define PRDT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("prdt assertion failed");

`define PRDT_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`else

`define PRDT_ASSERT(lbl, prop)

`define PRDT_ASSERT_MSG(lbl, prop, msg)

`endif

`endif

[rtl/core/prdt_pkg.sv]
// Shared types, codes and helpers for the prescaled reload down timer.
// No dependencies; used by every module of the block.
package prdt_pkg;

  localparam int unsigned DATA_W      = 16;
  localparam int unsigned PRESCALER_W = 8;
  localparam int unsigned DIV_SEL_W   = 2;
  localparam int unsigned DIV_CNT_W   = 4;
  localparam int unsigned CTL_W       = 5;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned CFG_ADDR_W  = 1;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;

  // Control register bit positions.
  localparam int unsigned CTL_START_BIT  = 0;
  localparam int unsigned CTL_MANUAL_BIT = 1;
  localparam int unsigned CTL_RELOAD_BIT = 3;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_BUFFER  = 2'd1,
    REG_COUNT   = 2'd2
  } reg_sel_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_PRESCALER  = 1'b0,
    CFG_DIV_SELECT = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [DATA_W-1:0] write_data;
    reg_sel_e          reg_select;
    op_e               op;
  } item_t;

  typedef struct packed {
    logic              running;
    logic              expired;
    logic [DATA_W-1:0] read_data;
  } result_t;

  // Terminal count of the divider stage: divide by 2^(sel+1).
  function automatic logic [DIV_CNT_W-1:0] div_limit(logic [DIV_SEL_W-1:0] sel);
    logic [DIV_CNT_W-1:0] lim;
    case (sel)
      2'd0:    lim = 4'd1;
      2'd1:    lim = 4'd3;
      2'd2:    lim = 4'd7;
      default: lim = 4'd15;
    endcase
    return lim;
  endfunction

endpackage

[rtl/core/prdt_tick_gen.sv]
// Prescaler and power-of-two divider that turn clock-tick beats into timer ticks.
// Depends on prdt_pkg.
module prdt_tick_gen #(
  parameter int unsigned PRESCALE_WIDTH = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 tick_en_i,
  input  logic [prdt_pkg::PRESCALER_W-1:0]     prescaler_i,
  input  logic [prdt_pkg::DIV_SEL_W-1:0]       div_select_i,
  output logic                                 fire_o
);

  localparam int unsigned LIM_W =
    (PRESCALE_WIDTH > prdt_pkg::PRESCALER_W) ? PRESCALE_WIDTH : prdt_pkg::PRESCALER_W;

  logic [PRESCALE_WIDTH-1:0]          pre_cnt_q, pre_cnt_d;
  logic [prdt_pkg::DIV_CNT_W-1:0]     div_cnt_q, div_cnt_d;
  logic [LIM_W-1:0]                   pre_limit;
  logic                               pre_wrap;
  logic                               div_wrap;

  // The prescaler value is masked to the counter width, as the count itself is.
  assign pre_limit = LIM_W'(prescaler_i) & LIM_W'({PRESCALE_WIDTH{1'b1}});
  assign pre_wrap  = LIM_W'(pre_cnt_q) >= pre_limit;
  assign div_wrap  = div_cnt_q >= prdt_pkg::div_limit(div_select_i);

  always_comb begin
    pre_cnt_d = pre_cnt_q;
    div_cnt_d = div_cnt_q;
    if (tick_en_i) begin
      if (pre_wrap) begin
        pre_cnt_d = '0;
        div_cnt_d = div_wrap ? '0 : div_cnt_q + 1'b1;
      end else begin
        pre_cnt_d = pre_cnt_q + 1'b1;
      end
    end
  end

  assign fire_o = tick_en_i && pre_wrap && div_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_cnt_q <= '0;
      div_cnt_q <= '0;
    end else begin
      pre_cnt_q <= pre_cnt_d;
      div_cnt_q <= div_cnt_d;
    end
  end

endmodule

[rtl/core/prdt_counter.sv]
// Timer register file and down counter: control bits, count buffer, reload logic.
// Depends on prdt_pkg.
module prdt_counter #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  prdt_pkg::item_t   item_i,
  input  logic              fire_i,
  output prdt_pkg::result_t result_o
);

  localparam int unsigned DW = prdt_pkg::DATA_W;
  localparam int unsigned XW = (COUNT_WIDTH > DW) ? COUNT_WIDTH : DW;

  logic [prdt_pkg::CTL_W-1:0] ctl_q, ctl_d;
  logic [COUNT_WIDTH-1:0]     buf_q, buf_d;
  logic [COUNT_WIDTH-1:0]     cnt_q, cnt_d;
  logic [COUNT_WIDTH-1:0]     cnt_dec;
  logic                       expired;
  logic [DW-1:0]              read_data;

  assign cnt_dec = cnt_q - 1'b1;

  always_comb begin
    ctl_d     = ctl_q;
    buf_d     = buf_q;
    cnt_d     = cnt_q;
    expired   = 1'b0;
    read_data = '0;
    case (item_i.op)
      prdt_pkg::OP_TICK: begin
        if (fire_i) begin
          if (ctl_q[prdt_pkg::CTL_MANUAL_BIT]) begin
            cnt_d = buf_q;
          end else if (ctl_q[prdt_pkg::CTL_START_BIT]) begin
            if (cnt_q == '0) begin
              // A tick that finds the counter already at zero does not flag expiry; it reloads only if reload is set.
              if (ctl_q[prdt_pkg::CTL_RELOAD_BIT]) cnt_d = buf_q;
            end else if (cnt_dec == '0) begin
              expired = 1'b1;
              cnt_d   = ctl_q[prdt_pkg::CTL_RELOAD_BIT] ? buf_q : cnt_dec;
            end else begin
              cnt_d = cnt_dec;
            end
          end
        end
      end
      prdt_pkg::OP_WRITE: begin
        case (item_i.reg_select)
          prdt_pkg::REG_CONTROL: ctl_d = item_i.write_data[prdt_pkg::CTL_W-1:0];
          prdt_pkg::REG_BUFFER:  buf_d = COUNT_WIDTH'(XW'(item_i.write_data));
          default: ;
        endcase
        if (ctl_d[prdt_pkg::CTL_MANUAL_BIT]) cnt_d = buf_d;
      end
      prdt_pkg::OP_READ: begin
        case (item_i.reg_select)
          prdt_pkg::REG_CONTROL: read_data = DW'(ctl_q);
          prdt_pkg::REG_BUFFER:  read_data = DW'(XW'(buf_q));
          prdt_pkg::REG_COUNT:   read_data = DW'(XW'(cnt_q));
          default:               read_data = '0;
        endcase
      end
      default: ;
    endcase
  end

  assign result_o.read_data = read_data;
  assign result_o.expired   = expired;
  assign result_o.running   = ctl_d[prdt_pkg::CTL_START_BIT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
      buf_q <= '0;
      cnt_q <= '0;
    end else if (step_i) begin
      ctl_q <= ctl_d;
      buf_q <= buf_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/core/prescaled_reload_down_timer.sv]
// Prescaled auto-reload down timer, top level with input and result registers.
// A beat accepted into the input register moves on to the result register once that is free or being read.
// Throughput: one beat per cycle while the result side does not stall.
// Reset (rst_ni low, asynchronous): counts, buffer, control and config clear.
// Depends on prdt_pkg, prdt_tick_gen, prdt_counter and the assertion header.
`include "prescaled_reload_down_timer_assert.svh"

module prescaled_reload_down_timer #(
  parameter int unsigned COUNT_WIDTH    = 16,
  parameter int unsigned PRESCALE_WIDTH = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Fields from bit 0: op[1:0], reg_select[3:2], write_data[19:4], zero pad.
  input  logic [prdt_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // Fields from bit 0: read_data[15:0], expired[16], running[17], zero pad.
  output logic [prdt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  input  logic                                cfg_we_i,
  input  logic [prdt_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [prdt_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  logic                                in_valid_q;
  prdt_pkg::item_t                     item_q;
  logic                                out_valid_q;
  prdt_pkg::result_t                   res_q;
  prdt_pkg::result_t                   res;
  logic                                advance;
  logic                                in_fire;
  logic                                fire;
  logic [prdt_pkg::PRESCALER_W-1:0]    prescaler_q;
  logic [prdt_pkg::DIV_SEL_W-1:0]      div_select_q;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescaler_q  <= '0;
      div_select_q <= '0;
    end else if (cfg_we_i) begin
      case (prdt_pkg::cfg_idx_e'(cfg_addr_i))
        prdt_pkg::CFG_PRESCALER:  prescaler_q  <= cfg_wdata_i;
        prdt_pkg::CFG_DIV_SELECT: div_select_q <= cfg_wdata_i[prdt_pkg::DIV_SEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.op         <= prdt_pkg::op_e'(s_axis_tdata_i[1:0]);
      item_q.reg_select <= prdt_pkg::reg_sel_e'(s_axis_tdata_i[3:2]);
      item_q.write_data <= s_axis_tdata_i[19:4];
    end
    if (advance) begin
      res_q <= res;
    end
  end

  prdt_tick_gen #(
    .PRESCALE_WIDTH (PRESCALE_WIDTH)
  ) u_tick_gen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_en_i    (advance && (item_q.op == prdt_pkg::OP_TICK)),
    .prescaler_i  (prescaler_q),
    .div_select_i (div_select_q),
    .fire_o       (fire)
  );

  prdt_counter #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_counter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .fire_i   (fire),
    .result_o (res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, res_q.running, res_q.expired, res_q.read_data};

  // Expiry can only come out of a clock-tick beat that fired the divider chain.
  `PRDT_ASSERT(a_expired_from_tick, advance && res.expired |-> fire && (item_q.op == prdt_pkg::OP_TICK))
  // Read data is zero for anything but a read beat.
  `PRDT_ASSERT(a_rdata_only_on_read, advance && (item_q.op != prdt_pkg::OP_READ) |-> res.read_data == '0)
  // Input side only stalls when both the input and result registers are full and blocked.
  `PRDT_ASSERT_MSG(a_stall_only_when_full, !s_axis_tready_o |-> in_valid_q && out_valid_q && !m_axis_tready_i, "prdt input stalled while a stage was free")
  // A beat that moves to the result register is presented in the next cycle.
  `PRDT_ASSERT(a_advance_gives_result, advance |=> m_axis_tvalid_o)

endmodule

[sim/timer_checker.sv]
// Scoreboard for the prescaled reload down timer: watches the input, result and config ports.
// It keeps its own model of the timer state and compares each result beat in order.
// Depends on prdt_pkg for the packet layout, op codes and register codes.
module timer_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [prdt_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                             s_tvalid_i,
  input  logic                             s_tready_i,
  input  logic [prdt_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  input  logic                             m_tvalid_i,
  input  logic                             m_tready_i,
  input  logic                             cfg_we_i,
  input  logic [prdt_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [prdt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output int                               fail_count_o,
  output int                               outstanding_o,
  output int                               results_seen_o,
  output int                               expiries_seen_o
);
  import prdt_pkg::*;

  logic [PRESCALER_W-1:0] prescale_cfg;
  logic [DIV_SEL_W-1:0]   div_sel_cfg;
  logic [PRESCALER_W-1:0] prescale_cnt;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [DATA_W-1:0]      down_cnt;
  logic [DATA_W-1:0]      reload_value;
  logic [CTL_W-1:0]       ctl_bits;

  result_t timer_results_q[$];

  // One input clock tick through both divider stages; high when a timer tick comes out.
  function automatic logic step_dividers();
    logic [DIV_CNT_W-1:0] div_top;
    div_top = DIV_CNT_W'((2 << div_sel_cfg) - 1);
    if (prescale_cnt < prescale_cfg) begin
      prescale_cnt = prescale_cnt + 1'b1;
      return 1'b0;
    end
    prescale_cnt = '0;
    if (div_cnt >= div_top) begin
      div_cnt = '0;
      return 1'b1;
    end
    div_cnt = div_cnt + 1'b1;
    return 1'b0;
  endfunction

  // One timer tick on the down counter; high when the count reaches zero.
  function automatic logic count_down();
    if (ctl_bits[CTL_MANUAL_BIT]) begin
      down_cnt = reload_value;
      return 1'b0;
    end
    if (!ctl_bits[CTL_START_BIT]) return 1'b0;
    if (down_cnt == '0) begin
      // A tick that finds the counter at zero never flags expiry.
      if (ctl_bits[CTL_RELOAD_BIT]) down_cnt = reload_value;
      return 1'b0;
    end
    down_cnt = down_cnt - 1'b1;
    if (down_cnt != '0) return 1'b0;
    if (ctl_bits[CTL_RELOAD_BIT]) down_cnt = reload_value;
    return 1'b1;
  endfunction

  function automatic result_t predict_timer_step(logic [1:0] op, logic [1:0] sel,
                                                 logic [DATA_W-1:0] wdata);
    result_t r;
    r = '0;
    case (op)
      OP_TICK: begin
        if (step_dividers()) r.expired = count_down();
      end
      OP_WRITE: begin
        if (sel == REG_CONTROL) ctl_bits = wdata[CTL_W-1:0];
        else if (sel == REG_BUFFER) reload_value = wdata;
        if (ctl_bits[CTL_MANUAL_BIT]) down_cnt = reload_value;
      end
      OP_READ: begin
        if (sel == REG_CONTROL) r.read_data = DATA_W'(ctl_bits);
        else if (sel == REG_BUFFER) r.read_data = reload_value;
        else if (sel == REG_COUNT) r.read_data = down_cnt;
      end
      default: ;
    endcase
    r.running = ctl_bits[CTL_START_BIT];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      prescale_cfg    = '0;
      div_sel_cfg     = '0;
      prescale_cnt    = '0;
      div_cnt         = '0;
      down_cnt        = '0;
      reload_value    = '0;
      ctl_bits        = '0;
      timer_results_q.delete();
      fail_count_o    = 0;
      results_seen_o  = 0;
      expiries_seen_o = 0;
    end else begin
      // Results are retired before the new beat is predicted, so a beat never meets itself.
      if (m_tvalid_i && m_tready_i) begin
        got.read_data = m_tdata_i[DATA_W-1:0];
        got.expired   = m_tdata_i[DATA_W];
        got.running   = m_tdata_i[DATA_W+1];
        results_seen_o++;
        if (got.expired) expiries_seen_o++;
        if (timer_results_q.size() == 0) begin
          $error("result beat with nothing expected: tdata %h", m_tdata_i);
          fail_count_o++;
        end else begin
          want = timer_results_q.pop_front();
          if (got.read_data !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, got.read_data);
            fail_count_o++;
          end
          if (got.expired !== want.expired) begin
            $error("expired: expected %b, got %b", want.expired, got.expired);
            fail_count_o++;
          end
          if (got.running !== want.running) begin
            $error("running: expected %b, got %b", want.running, got.running);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i)
        timer_results_q.push_back(predict_timer_step(s_tdata_i[1:0], s_tdata_i[3:2],
                                                     s_tdata_i[DATA_W+3:4]));
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_PRESCALER) prescale_cfg = cfg_wdata_i;
        else div_sel_cfg = cfg_wdata_i[DIV_SEL_W-1:0];
      end
    end
    outstanding_o = timer_results_q.size();
  end

endmodule

[sim/testbench.sv]
// Top of the timer testbench: clock, reset, stimulus, handshake pressure and the verdict.
// Directed register and expiry cases come first, then random ticks, writes and reads.
// Depends on prdt_pkg, the prescaled_reload_down_timer RTL and timer_checker.
module testbench;
  import prdt_pkg::*;

  localparam logic [1:0]        OP_NONE  = 2'd3;
  localparam logic [1:0]        REG_NONE = 2'd3;
  localparam logic [DATA_W-1:0] CTL_RUN  = DATA_W'(1 << CTL_START_BIT);
  localparam logic [DATA_W-1:0] CTL_LOAD = DATA_W'(1 << CTL_MANUAL_BIT);
  localparam logic [DATA_W-1:0] CTL_AUTO = DATA_W'(1 << CTL_RELOAD_BIT);
  localparam int                STALL_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int fail_count;
  int outstanding;
  int results_seen;
  int expiries_seen;
  int items_sent;
  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold_left;

  prescaled_reload_down_timer uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata)
  );

  timer_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_tdata_i       (s_tdata),
    .s_tvalid_i      (s_tvalid),
    .s_tready_i      (s_tready),
    .m_tdata_i       (m_tdata),
    .m_tvalid_i      (m_tvalid),
    .m_tready_i      (m_tready),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .fail_count_o    (fail_count),
    .outstanding_o   (outstanding),
    .results_seen_o  (results_seen),
    .expiries_seen_o (expiries_seen)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        m_tready = 1'b0;
        rx_hold_left--;
      end else begin
        m_tready = ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Ends the run if neither side moves a beat for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("testbench: FAIL");
          $finish;
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic offer_beat(input logic [1:0] op, input logic [1:0] sel,
                            input logic [DATA_W-1:0] wdata);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid = 1'b1;
    s_tdata  = {4'b0, wdata, sel, op};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic offer_ticks(input int n);
    repeat (n) offer_beat(OP_TICK, REG_NONE, DATA_W'($urandom));
  endtask

  // Stops offering and waits until every result has come back.
  task automatic drain_timer();
    s_tvalid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    drain_timer();
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk_i);
    cfg_we    = 1'b0;
  endtask

  task automatic offer_random_item();
    int pick;
    logic [1:0] sel;
    logic [DATA_W-1:0] wdata;
    pick  = $urandom_range(99);
    sel   = 2'($urandom);
    wdata = DATA_W'($urandom);
    if (pick < 70) begin
      offer_beat(OP_TICK, sel, wdata);
    end else if (pick < 84) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        // Mostly running, sometimes manual update, reload more often than not.
        wdata[CTL_START_BIT]  = ($urandom_range(99) < 85);
        wdata[CTL_MANUAL_BIT] = ($urandom_range(99) < 15);
        wdata[CTL_RELOAD_BIT] = ($urandom_range(99) < 60);
        sel = REG_CONTROL;
      end else if (pick < 90) begin
        // Short periods so that expiry comes often.
        if ($urandom_range(99) < 80) wdata = DATA_W'($urandom_range(24));
        sel = REG_BUFFER;
      end else begin
        sel = $urandom_range(1) ? REG_COUNT : REG_NONE;
      end
      offer_beat(OP_WRITE, sel, wdata);
    end else if (pick < 98) begin
      offer_beat(OP_READ, sel, wdata);
    end else begin
      offer_beat(OP_NONE, sel, wdata);
    end
  endtask

  initial begin
    int prescale_tab[4][2];
    int div_tab[4][2];
    int tx_tab[4];
    int rx_tab[4];
    prescale_tab = '{'{0, 3}, '{255, 2}, '{0, 7}, '{1, 0}};
    div_tab      = '{'{0, 1}, '{3, 0}, '{2, 1}, '{3, 0}};
    tx_tab       = '{0, 51, 0, 29};
    rx_tab       = '{0, 0, 51, 29};
    items_sent   = 0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    rx_hold_left = 0;
    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_PRESCALER;
    cfg_wdata = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part: reset values, unused selectors, manual load, expiry with and
    // without reload, and ticks that find the counter already at zero.
    write_cfg(CFG_PRESCALER, 8'd0);
    write_cfg(CFG_DIV_SELECT, 8'hfc);
    offer_beat(OP_READ, REG_CONTROL, '0);
    offer_beat(OP_READ, REG_BUFFER, '0);
    offer_beat(OP_READ, REG_COUNT, '0);
    offer_beat(OP_READ, REG_NONE, '1);
    offer_beat(OP_NONE, REG_NONE, '1);
    offer_beat(OP_WRITE, REG_BUFFER, '1);
    offer_beat(OP_WRITE, REG_CONTROL, '1);
    offer_beat(OP_READ, REG_COUNT, '0);
    offer_beat(OP_READ, REG_CONTROL, '0);
    offer_beat(OP_WRITE, REG_COUNT, 16'h1234);
    offer_beat(OP_WRITE, REG_NONE, '0);
    offer_beat(OP_WRITE, REG_BUFFER, 16'd3);
    offer_beat(OP_WRITE, REG_CONTROL, CTL_RUN | CTL_AUTO);
    offer_ticks(6);
    offer_beat(OP_WRITE, REG_CONTROL, CTL_RUN);
    offer_ticks(8);
    offer_beat(OP_READ, REG_COUNT, '0);
    offer_beat(OP_WRITE, REG_BUFFER, '0);
    offer_beat(OP_WRITE, REG_CONTROL, CTL_RUN | CTL_AUTO | CTL_LOAD);
    offer_beat(OP_WRITE, REG_CONTROL, CTL_RUN | CTL_AUTO);
    offer_ticks(3);

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = tx_tab[ph];
      rx_stall_pct = rx_tab[ph];
      for (int half = 0; half < 2; half++) begin
        write_cfg(CFG_PRESCALER, CFG_DATA_W'(prescale_tab[ph][half]));
        write_cfg(CFG_DIV_SELECT, {6'($urandom), 2'(div_tab[ph][half])});
        for (int n = 0; n < 212; n++) begin
          // In the first phase the result side holds off while beats keep coming,
          // and later the sender waits for the pipeline to empty.
          if (ph == 0 && half == 0 && n == 100) rx_hold_left = 300;
          if (ph == 0 && half == 0 && n == 150) drain_timer();
          offer_random_item();
        end
      end
    end

    drain_timer();
    repeat (8) @(negedge clk_i);
    $display("Sent %0d beats of ticks, register writes and reads under four handshake mixes",
             items_sent);
    $display("and eight prescaler/divider settings; %0d results checked, %0d expiries.",
             results_seen, expiries_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/prdt_pkg.sv
rtl/core/prdt_tick_gen.sv
rtl/core/prdt_counter.sv
rtl/core/prescaled_reload_down_timer.sv
sim/timer_checker.sv
sim/testbench.sv
